// ===== hdl/bcl_pkg.sv =====
`timescale 1ns / 1ps

package bcl_pkg;

	// Word widths
	localparam int SAMPLE_W   = 24;
	localparam int STATE_W    = 32;
	localparam int COEF_W     = 21;
	localparam int COEF_REG_W = 63;
	localparam int PROD_W     = COEF_W + STATE_W;
	localparam int ACC_W      = PROD_W + 3;
	localparam int FRAC_SHIFT = 18;
	localparam int CH_W       = 3;
	localparam int CNT_W      = 4;
	localparam int IDX_W      = 3;

	// Coefficient fields inside a packed stage register
	localparam int B0_LSB = 0;
	localparam int A1_LSB = COEF_W;
	localparam int A2_LSB = 2 * COEF_W;

	// Register map
	localparam int NUM_COEFF_REGS = 4;
	localparam int CREG_W         = 2;
	localparam logic [IDX_W-1:0] REG_CHANNELS = IDX_W'(NUM_COEFF_REGS);
	localparam logic [CNT_W-1:0] CHANNELS_RESET = CNT_W'(2);

	// Default sizing
	localparam int MAX_CHANNELS_DEF = 8;
	localparam int NUM_SECTIONS_DEF = 4;

	typedef enum logic [1:0] {
		MUL_B0,
		MUL_A1,
		MUL_A2
	} mul_op_t;

	typedef enum logic [1:0] {
		ADD_Y,
		ADD_N1,
		ADD_N2
	} add_op_t;

	typedef struct packed {
		logic    load_in;
		logic    mul_en;
		mul_op_t mul_op;
		add_op_t add_op;
		logic    y_en;
		logic    n1_en;
	} ctl_t;

endpackage

// ===== hdl/bcl_ram.sv =====
`timescale 1ns / 1ps

module bcl_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one entry, register the read word
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== hdl/bcl_alu.sv =====
`timescale 1ns / 1ps

module bcl_alu (
	input  logic                                  clk,
	input  bcl_pkg::ctl_t                         ctl,
	input  logic [bcl_pkg::COEF_REG_W-1:0]        coeff,
	input  logic signed [bcl_pkg::SAMPLE_W-1:0]   sample,
	input  logic signed [bcl_pkg::STATE_W-1:0]    d1,
	input  logic signed [bcl_pkg::STATE_W-1:0]    d2,
	output logic signed [bcl_pkg::STATE_W-1:0]    y,
	output logic signed [bcl_pkg::STATE_W-1:0]    n1,
	output logic signed [bcl_pkg::STATE_W-1:0]    res
);

	localparam int RND_W = bcl_pkg::ACC_W - bcl_pkg::FRAC_SHIFT;
	localparam int OVF_W = RND_W - bcl_pkg::STATE_W + 1;
	localparam logic signed [bcl_pkg::ACC_W-1:0] HALF_LSB =
		bcl_pkg::ACC_W'(1) <<< (bcl_pkg::FRAC_SHIFT - 1);

	logic signed [bcl_pkg::COEF_W-1:0]  mul_a;
	logic signed [bcl_pkg::PROD_W-1:0]  prod;
	logic signed [bcl_pkg::PROD_W-1:0]  prod_q;
	logic signed [bcl_pkg::PROD_W-1:0]  bx_q;
	logic signed [bcl_pkg::STATE_W-1:0] y_q;
	logic signed [bcl_pkg::STATE_W-1:0] n1_q;
	logic signed [bcl_pkg::ACC_W-1:0]   term_a;
	logic signed [bcl_pkg::ACC_W-1:0]   term_p;
	logic signed [bcl_pkg::ACC_W-1:0]   term_d;
	logic signed [bcl_pkg::ACC_W-1:0]   sum;
	logic signed [RND_W-1:0]            rnd;
	logic                               ovf;

	// Pick the coefficient for the shared multiplier
	always_comb begin
		unique case (ctl.mul_op)
			bcl_pkg::MUL_B0: mul_a = coeff[bcl_pkg::B0_LSB +: bcl_pkg::COEF_W];
			bcl_pkg::MUL_A1: mul_a = coeff[bcl_pkg::A1_LSB +: bcl_pkg::COEF_W];
			bcl_pkg::MUL_A2: mul_a = coeff[bcl_pkg::A2_LSB +: bcl_pkg::COEF_W];
			default:         mul_a = coeff[bcl_pkg::B0_LSB +: bcl_pkg::COEF_W];
		endcase
	end

	assign prod = mul_a * y_q;

	// Sum with rounding: folding the delay word in above the dropped bits
	// gives the same result as rounding first and adding it afterwards
	always_comb begin
		unique case (ctl.add_op)
			bcl_pkg::ADD_Y: begin
				term_a = '0;
				term_p = bcl_pkg::ACC_W'(prod_q);
				term_d = bcl_pkg::ACC_W'(d1) <<< bcl_pkg::FRAC_SHIFT;
			end
			bcl_pkg::ADD_N1: begin
				term_a = bcl_pkg::ACC_W'(bx_q) <<< 1;
				term_p = -bcl_pkg::ACC_W'(prod_q);
				term_d = bcl_pkg::ACC_W'(d2) <<< bcl_pkg::FRAC_SHIFT;
			end
			bcl_pkg::ADD_N2: begin
				term_a = bcl_pkg::ACC_W'(bx_q);
				term_p = -bcl_pkg::ACC_W'(prod_q);
				term_d = '0;
			end
			default: begin
				term_a = '0;
				term_p = '0;
				term_d = '0;
			end
		endcase
		sum = term_a + term_p + term_d + HALF_LSB;
		rnd = sum[bcl_pkg::ACC_W-1:bcl_pkg::FRAC_SHIFT];
		ovf = (rnd[RND_W-1:bcl_pkg::STATE_W-1] != {OVF_W{rnd[bcl_pkg::STATE_W-1]}});
		if (ovf) begin
			res = rnd[RND_W-1] ? {1'b1, {(bcl_pkg::STATE_W-1){1'b0}}}
				: {1'b0, {(bcl_pkg::STATE_W-1){1'b1}}};
		end else begin
			res = rnd[bcl_pkg::STATE_W-1:0];
		end
	end

	// Hold product, b0*x, section output and the new first delay
	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_q <= prod;
		end
		if (ctl.y_en) begin
			bx_q <= prod_q;
		end
		if (ctl.load_in) begin
			y_q <= bcl_pkg::STATE_W'(sample);
		end else if (ctl.y_en) begin
			y_q <= res;
		end
		if (ctl.n1_en) begin
			n1_q <= res;
		end
	end

	assign y  = y_q;
	assign n1 = n1_q;

endmodule

// ===== hdl/bcl_seq.sv =====
`timescale 1ns / 1ps

module bcl_seq #(
	parameter int MAX_CHANNELS = bcl_pkg::MAX_CHANNELS_DEF,
	parameter int NUM_SECTIONS = bcl_pkg::NUM_SECTIONS_DEF,
	localparam int DEPTH = MAX_CHANNELS * NUM_SECTIONS,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        bad,
	input  logic [bcl_pkg::CH_W-1:0]    ch,
	input  logic                        out_stall,
	output logic                        in_stall,
	output logic                        out_valid,
	output logic                        out_load,
	output bcl_pkg::ctl_t               ctl,
	output logic [bcl_pkg::CREG_W-1:0]  creg_sel,
	output logic                        rd_en,
	output logic [AW-1:0]               rd_addr,
	output logic                        wr_en,
	output logic [AW-1:0]               wr_addr
);

	localparam int SW = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_YS,
		ST_M1,
		ST_N1,
		ST_N2,
		ST_FIN
	} state_t;

	state_t                      state_q;
	logic [SW-1:0]               sec_q;
	logic [AW-1:0]               base_q;
	logic [bcl_pkg::CREG_W-1:0]  creg_q;
	logic                        out_valid_q;
	logic                        last;
	logic [AW-1:0]               cur_addr;

	assign last     = (sec_q == SW'(NUM_SECTIONS - 1));
	assign cur_addr = base_q + AW'(ch);
	assign wr_addr  = cur_addr;
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// Decode the step into datapath and memory controls
	always_comb begin
		ctl         = '0;
		ctl.mul_op  = bcl_pkg::MUL_B0;
		ctl.add_op  = bcl_pkg::ADD_Y;
		rd_en       = 1'b0;
		rd_addr     = cur_addr;
		wr_en       = 1'b0;
		creg_sel    = creg_q;
		out_load    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				ctl.load_in = in_valid;
			end
			ST_RD: begin
				ctl.mul_en = 1'b1;
				rd_en      = 1'b1;
			end
			ST_YS: begin
				ctl.add_op = bcl_pkg::ADD_Y;
				ctl.y_en   = 1'b1;
			end
			ST_M1: begin
				ctl.mul_en = 1'b1;
				ctl.mul_op = bcl_pkg::MUL_A1;
			end
			ST_N1: begin
				ctl.mul_en = 1'b1;
				ctl.mul_op = bcl_pkg::MUL_A2;
				ctl.add_op = bcl_pkg::ADD_N1;
				ctl.n1_en  = 1'b1;
			end
			ST_N2: begin
				// Write back this section, start the next one unless this is the last
				ctl.add_op = bcl_pkg::ADD_N2;
				wr_en      = 1'b1;
				creg_sel   = creg_q + 1'b1;
				rd_addr    = cur_addr + AW'(MAX_CHANNELS);
				if (!last) begin
					ctl.mul_en = 1'b1;
					rd_en      = 1'b1;
				end
			end
			ST_FIN: begin
				out_load = !out_valid_q || !out_stall;
			end
			default: begin
				ctl.load_in = 1'b0;
			end
		endcase
	end

	// Advance the sequencer, hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sec_q       <= '0;
			base_q      <= '0;
			creg_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						sec_q   <= '0;
						base_q  <= '0;
						creg_q  <= '0;
						state_q <= bad ? ST_FIN : ST_RD;
					end
				end
				ST_RD: state_q <= ST_YS;
				ST_YS: state_q <= ST_M1;
				ST_M1: state_q <= ST_N1;
				ST_N1: state_q <= ST_N2;
				ST_N2: begin
					if (last) begin
						state_q <= ST_FIN;
					end else begin
						sec_q   <= sec_q + 1'b1;
						base_q  <= base_q + AW'(MAX_CHANNELS);
						creg_q  <= creg_q + 1'b1;
						state_q <= ST_YS;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hdl/biquad_cascade_lowpass.sv =====
`timescale 1ns / 1ps

// Cascaded biquad low-pass for interleaved audio: each sample runs through
// NUM_SECTIONS transposed direct form II sections (b1 = 2*b0, b2 = b0) with
// per-channel delay words, and the last output is saturated to Q1.23. One
// 21x32 multiplier and one rounding adder are shared by all sections; each
// section steps through b0*x, y, a1*y and a2*y with the delay updates. A sample
// or a rejected channel holds the block until its result is loaded. The result
// sits in an output register, so the next sample is taken while it waits.
// Delay words live in one RAM of MAX_CHANNELS*NUM_SECTIONS entries; per-entry
// valid bits make them read as zero after reset, with no clearing pass.
module biquad_cascade_lowpass #(
	parameter int MAX_CHANNELS = bcl_pkg::MAX_CHANNELS_DEF,
	parameter int NUM_SECTIONS = bcl_pkg::NUM_SECTIONS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [bcl_pkg::IDX_W-1:0]           cfg_index,
	input  logic [bcl_pkg::COEF_REG_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [bcl_pkg::CH_W-1:0]            channel,
	input  logic signed [bcl_pkg::SAMPLE_W-1:0] sample,
	input  logic                                block_end,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [bcl_pkg::CH_W-1:0]            out_channel,
	output logic signed [bcl_pkg::SAMPLE_W-1:0] filtered_sample,
	output logic                                out_block_end,
	output logic                                bad_channel
);

	localparam int DEPTH = MAX_CHANNELS * NUM_SECTIONS;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW = bcl_pkg::STATE_W;
	localparam int OW = bcl_pkg::SAMPLE_W;

	logic [bcl_pkg::COEF_REG_W-1:0] stage_q [bcl_pkg::NUM_COEFF_REGS];
	logic [bcl_pkg::CNT_W-1:0]      chans_q;
	logic [bcl_pkg::CH_W-1:0]       ch_q;
	logic                           blk_q;
	logic                           bad_q;
	logic [DEPTH-1:0]               valid_q;
	logic                           rd_valid_q;

	logic                           accept;
	logic                           bad;
	logic                           out_load;
	bcl_pkg::ctl_t                  ctl;
	logic [bcl_pkg::CREG_W-1:0]     creg_sel;
	logic                           rd_en;
	logic                           wr_en;
	logic [AW-1:0]                  rd_addr;
	logic [AW-1:0]                  wr_addr;
	logic [2*SW-1:0]                rd_data;
	logic signed [SW-1:0]           d1;
	logic signed [SW-1:0]           d2;
	logic signed [SW-1:0]           y;
	logic signed [SW-1:0]           n1;
	logic signed [SW-1:0]           res;
	logic signed [OW-1:0]           y_sat;

	assign accept = in_valid && !in_stall;
	assign bad = ({1'b0, channel} >= chans_q) || (32'(channel) >= MAX_CHANNELS);

	// Configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bcl_pkg::NUM_COEFF_REGS; i++) begin
				stage_q[i] <= '0;
			end
			chans_q <= bcl_pkg::CHANNELS_RESET;
		end else if (cfg_we) begin
			if (cfg_index < bcl_pkg::REG_CHANNELS) begin
				stage_q[cfg_index[bcl_pkg::CREG_W-1:0]] <= cfg_data;
			end else if (cfg_index == bcl_pkg::REG_CHANNELS) begin
				chans_q <= cfg_data[bcl_pkg::CNT_W-1:0];
			end
		end
	end

	// Capture the item fields at accept
	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q  <= channel;
			blk_q <= block_end;
			bad_q <= bad;
		end
	end

	// Track which delay entries were ever written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign d1 = rd_valid_q ? rd_data[2*SW-1:SW] : '0;
	assign d2 = rd_valid_q ? rd_data[SW-1:0] : '0;

	bcl_seq #(
		.MAX_CHANNELS (MAX_CHANNELS),
		.NUM_SECTIONS (NUM_SECTIONS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.bad       (bad),
		.ch        (ch_q),
		.out_stall (out_stall),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_load  (out_load),
		.ctl       (ctl),
		.creg_sel  (creg_sel),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr)
	);

	bcl_alu u_alu (
		.clk    (clk),
		.ctl    (ctl),
		.coeff  (stage_q[creg_sel]),
		.sample (sample),
		.d1     (d1),
		.d2     (d2),
		.y      (y),
		.n1     (n1),
		.res    (res)
	);

	bcl_ram #(
		.WIDTH (2 * SW),
		.DEPTH (DEPTH)
	) u_delay_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data ({n1, res}),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Saturate the last section output to Q1.23
	always_comb begin
		if (y[SW-1:OW-1] != {(SW-OW+1){y[OW-1]}}) begin
			y_sat = y[SW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
		end else begin
			y_sat = y[OW-1:0];
		end
	end

	// Output word register
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_channel     <= ch_q;
			out_block_end   <= blk_q;
			bad_channel     <= bad_q;
			filtered_sample <= bad_q ? '0 : y_sat;
		end
	end

endmodule

// ===== dv/biquad_cascade_lowpass_test.sv =====
`timescale 1ns / 1ps

module biquad_cascade_lowpass_test;

	localparam int MAX_CH   = bcl_pkg::MAX_CHANNELS_DEF;
	localparam int NSEC     = bcl_pkg::NUM_SECTIONS_DEF;
	localparam int LATENCY  = 4 * NSEC + 3;
	localparam int IDLE_PAD = LATENCY + 5;
	localparam int WATCHDOG = 3000;

	// Widths and register map of the block
	localparam int IDX_W          = bcl_pkg::IDX_W;
	localparam int COEF_W         = bcl_pkg::COEF_W;
	localparam int COEF_REG_W     = bcl_pkg::COEF_REG_W;
	localparam int SAMPLE_W       = bcl_pkg::SAMPLE_W;
	localparam int STATE_W        = bcl_pkg::STATE_W;
	localparam int CH_W           = bcl_pkg::CH_W;
	localparam int CNT_W          = bcl_pkg::CNT_W;
	localparam int NUM_COEFF_REGS = bcl_pkg::NUM_COEFF_REGS;
	localparam int FRAC_SHIFT     = bcl_pkg::FRAC_SHIFT;
	localparam int B0_LSB         = bcl_pkg::B0_LSB;
	localparam int A1_LSB         = bcl_pkg::A1_LSB;
	localparam int A2_LSB         = bcl_pkg::A2_LSB;
	localparam logic [IDX_W-1:0] REG_CHANNELS   = bcl_pkg::REG_CHANNELS;
	localparam logic [CNT_W-1:0] CHANNELS_RESET = bcl_pkg::CHANNELS_RESET;

	// Register indexes beside the package's channel-count register
	localparam logic [IDX_W-1:0] REG_STAGE0       = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_FIRST_UNUSED = REG_CHANNELS + IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_LAST_INDEX   = {IDX_W{1'b1}};

	// Q3.18 coefficient values
	localparam logic [COEF_W-1:0] Q_ONE    = 21'h040000;
	localparam logic [COEF_W-1:0] Q_TWO    = 21'h080000;
	localparam logic [COEF_W-1:0] COEF_MAX = 21'h0FFFFF;
	localparam logic [COEF_W-1:0] COEF_MIN = 21'h100000;

	localparam logic signed [SAMPLE_W-1:0] SMP_MAX = 24'sh7FFFFF;
	localparam logic signed [SAMPLE_W-1:0] SMP_MIN = 24'sh800000;

	typedef enum int {
		KIND_DESIGNED,
		KIND_RAW,
		KIND_EXTREME
	} coef_kind_t;

	typedef struct packed {
		logic [CH_W-1:0]            ch;
		logic signed [SAMPLE_W-1:0] smp;
		logic                       blk;
		logic                       bad;
	} sample_result_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [IDX_W-1:0]           cfg_index;
	logic [COEF_REG_W-1:0]      cfg_data;
	logic                       in_valid;
	logic                       in_stall;
	logic [CH_W-1:0]            channel;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       block_end;
	logic                       out_valid;
	logic                       out_stall;
	logic [CH_W-1:0]            out_channel;
	logic signed [SAMPLE_W-1:0] filtered_sample;
	logic                       out_block_end;
	logic                       bad_channel;

	// Predictor copy of configuration and delay words
	logic [COEF_REG_W-1:0] stage_coeff [NUM_COEFF_REGS];
	logic [CNT_W-1:0]      active_count;
	logic signed [STATE_W-1:0] delay_first  [MAX_CH*NSEC];
	logic signed [STATE_W-1:0] delay_second [MAX_CH*NSEC];

	sample_result_t pending_results [$];
	sample_result_t want;
	int             errors;
	int             quiet_cycles;
	logic           calm;

	biquad_cascade_lowpass dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.channel        (channel),
		.sample         (sample),
		.block_end      (block_end),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_channel    (out_channel),
		.filtered_sample(filtered_sample),
		.out_block_end  (out_block_end),
		.bad_channel    (bad_channel)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Signed 21-bit coefficient field of a packed stage word
	function automatic longint coeff_at(logic [COEF_REG_W-1:0] word, int lsb);
		logic signed [COEF_W-1:0] f;
		f = word[lsb +: COEF_W];
		return f;
	endfunction

	// Round 41 fraction bits down to 23, half up
	function automatic longint round_q41(longint acc);
		return (acc + 64'sd131072) >>> FRAC_SHIFT;
	endfunction

	function automatic longint sat32(longint v);
		if (v > longint'(2147483647))
			return 2147483647;
		if (v < -longint'(2147483647) - 1)
			return -longint'(2147483647) - 1;
		return v;
	endfunction

	// Run one sample through the cascade and advance the delay words
	function automatic sample_result_t filter_cascade(logic [CH_W-1:0] ch,
			logic signed [SAMPLE_W-1:0] smp, logic blk);
		sample_result_t r;
		longint x, bx, b0, a1, a2, y, n1, n2;
		int s, idx;
		r.ch  = ch;
		r.blk = blk;
		r.smp = '0;
		r.bad = 1'b1;
		if (ch >= active_count || ch >= MAX_CH)
			return r;
		x = smp;
		for (s = 0; s < NSEC; s++) begin
			b0 = coeff_at(stage_coeff[s % NUM_COEFF_REGS], B0_LSB);
			a1 = coeff_at(stage_coeff[s % NUM_COEFF_REGS], A1_LSB);
			a2 = coeff_at(stage_coeff[s % NUM_COEFF_REGS], A2_LSB);
			idx = s * MAX_CH + ch;
			bx = b0 * x;
			y  = sat32(round_q41(bx) + delay_first[idx]);
			n1 = sat32(round_q41(2 * bx - a1 * y) + delay_second[idx]);
			n2 = sat32(round_q41(bx - a2 * y));
			delay_first[idx]  = n1[STATE_W-1:0];
			delay_second[idx] = n2[STATE_W-1:0];
			x = y;
		end
		if (x > 8388607)
			x = 8388607;
		if (x < -8388608)
			x = -8388608;
		r.smp = x[SAMPLE_W-1:0];
		r.bad = 1'b0;
		return r;
	endfunction

	function automatic logic [COEF_REG_W-1:0] pack_coeffs(logic [COEF_W-1:0] b0,
			logic [COEF_W-1:0] a1, logic [COEF_W-1:0] a2);
		return {a2, a1, b0};
	endfunction

	function automatic logic [COEF_W-1:0] to_q318(real v);
		int q;
		q = $rtoi(v * 262144.0);
		return q[COEF_W-1:0];
	endfunction

	// Stable low-pass section with unity gain at DC
	function automatic logic [COEF_REG_W-1:0] design_lowpass();
		real r, c, a1, a2, b0;
		r  = 0.5 + 0.48 * $urandom_range(1000) / 1000.0;
		c  = 0.3 + 0.69 * $urandom_range(1000) / 1000.0;
		a1 = -2.0 * r * c;
		a2 = r * r;
		b0 = (1.0 + a1 + a2) / 4.0;
		return pack_coeffs(to_q318(b0), to_q318(a1), to_q318(a2));
	endfunction

	function automatic logic [COEF_W-1:0] edge_coeff();
		case ($urandom_range(3))
			0: return COEF_MAX;
			1: return COEF_MIN;
			2: return '0;
			default: return '1;
		endcase
	endfunction

	function automatic logic [COEF_REG_W-1:0] pick_coeffs(coef_kind_t kind);
		logic [63:0] raw;
		case (kind)
			KIND_RAW: begin
				raw = {$urandom, $urandom};
				return raw[COEF_REG_W-1:0];
			end
			KIND_EXTREME: return pack_coeffs(edge_coeff(), edge_coeff(), edge_coeff());
			default: return design_lowpass();
		endcase
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint exp_v);
		errors++;
		$display("mismatch in %s: got %0d, expected %0d", what, got, exp_v);
	endtask

	// Write one register; hold the block idle around it
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [COEF_REG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx < NUM_COEFF_REGS)
			stage_coeff[idx] = val;
		else if (idx == REG_CHANNELS)
			active_count = val[CNT_W-1:0];
	endtask

	// Offer one word and hold it until taken; leave valid high for the next one
	task automatic send_sample(input logic [CH_W-1:0] ch, input logic signed [SAMPLE_W-1:0] smp,
			input logic blk);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(99) < 28)
			gap = $urandom_range(1, 22);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		channel   <= ch;
		sample    <= smp;
		block_end <= blk;
		in_valid  <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_results.push_back(filter_cascade(ch, smp, blk));
	endtask

	// Drop valid and wait until every expected word has come back
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (IDLE_PAD) @(posedge clk);
	endtask

	task automatic write_stages(input coef_kind_t kind);
		int s;
		for (s = 0; s < NUM_COEFF_REGS; s++)
			write_reg(REG_STAGE0 + IDX_W'(s), pick_coeffs(kind));
	endtask

	task automatic write_count(input int count);
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		raw[CNT_W-1:0] = count[CNT_W-1:0];
		write_reg(REG_CHANNELS, raw[COEF_REG_W-1:0]);
	endtask

	// Zero coefficients and two channels out of reset
	task automatic test_reset_state();
		int c;
		for (c = 0; c < MAX_CH; c++)
			send_sample(CH_W'(c), c[0] ? SMP_MAX : SMP_MIN, c == MAX_CH - 1);
		wait_idle();
	endtask

	// Pole-zero cancelling sections pass samples through unchanged
	task automatic test_passthrough();
		int s;
		write_count(MAX_CH);
		for (s = 0; s < NUM_COEFF_REGS; s++)
			write_reg(REG_STAGE0 + IDX_W'(s), pack_coeffs(Q_ONE, Q_TWO, Q_ONE));
		send_sample(3'd0, SMP_MAX, 1'b0);
		send_sample(3'd1, SMP_MIN, 1'b1);
		send_sample(3'd2, '0, 1'b0);
		send_sample(3'd3, 24'sd1, 1'b1);
		send_sample(3'd7, -24'sd1, 1'b0);
		wait_idle();
	endtask

	// Largest gain and feedback drive state and output into saturation
	task automatic test_saturation();
		int s;
		for (s = 0; s < NUM_COEFF_REGS; s++)
			write_reg(REG_STAGE0 + IDX_W'(s), pack_coeffs(COEF_MAX, COEF_MIN, COEF_MIN));
		send_sample(3'd0, SMP_MAX, 1'b0);
		send_sample(3'd0, SMP_MIN, 1'b1);
		send_sample(3'd1, SMP_MAX, 1'b0);
		wait_idle();
	endtask

	// Zero count, count above the channel limit, one channel, unknown indexes
	task automatic test_channel_count();
		logic [IDX_W-1:0] idx;
		write_count(0);
		send_sample(3'd0, SMP_MAX, 1'b1);
		wait_idle();
		write_count(15);
		send_sample(3'd7, SMP_MIN, 1'b0);
		wait_idle();
		write_count(1);
		send_sample(3'd0, 24'sd12345, 1'b0);
		send_sample(3'd1, -24'sd5, 1'b1);
		wait_idle();
		idx = REG_FIRST_UNUSED;
		forever begin
			write_reg(idx, '1);
			if (idx == REG_LAST_INDEX)
				break;
			idx++;
		end
		send_sample(3'd0, SMP_MAX, 1'b1);
		wait_idle();
	endtask

	// Random interleaved audio in order, with some stray channel numbers
	task automatic random_burst(input int count, input int items);
		int i, lanes, rr, v;
		logic [CH_W-1:0] ch;
		logic signed [SAMPLE_W-1:0] smp;
		lanes = (count == 0) ? 1 : ((count > MAX_CH) ? MAX_CH : count);
		rr = 0;
		for (i = 0; i < items; i++) begin
			if ($urandom_range(99) < 88) begin
				ch = CH_W'(rr);
				rr = (rr + 1) % lanes;
			end else begin
				ch = CH_W'($urandom_range(MAX_CH - 1));
			end
			case ($urandom_range(9))
				0, 1, 2, 3: smp = SAMPLE_W'($urandom);
				8, 9: begin
					case ($urandom_range(2))
						0: smp = SMP_MAX;
						1: smp = SMP_MIN;
						default: smp = '0;
					endcase
				end
				default: begin
					v = $urandom_range(0, 524288);
					smp = SAMPLE_W'(v - 262144);
				end
			endcase
			send_sample(ch, smp, ($urandom_range(9) == 0) || (rr == 0 && i % 4 == 3));
		end
	endtask

	// The sender stops until every result is back, then carries on
	task automatic test_sender_pause();
		write_stages(KIND_DESIGNED);
		write_count(4);
		random_burst(4, 40);
		wait_idle();
		random_burst(4, 40);
		wait_idle();
	endtask

	// Phases over many coefficient and channel-count settings
	task automatic test_random_filtering();
		int p, count;
		coef_kind_t kind;
		for (p = 0; p < 16; p++) begin
			if (p % 5 == 3)
				kind = KIND_RAW;
			else if (p % 5 == 4)
				kind = KIND_EXTREME;
			else
				kind = KIND_DESIGNED;
			if (p == 0)
				count = MAX_CH;
			else if (p == 1)
				count = 1;
			else if (p == 6)
				count = 0;
			else if (p == 9)
				count = 15;
			else if (p % 4 == 2)
				count = $urandom_range(9, 15);
			else
				count = $urandom_range(1, MAX_CH);
			write_stages(kind);
			write_count(count);
			calm = (p == 5);
			random_burst(count, 80);
			wait_idle();
			calm = 1'b0;
		end
	endtask

	// Receiver stall
	always @(posedge clk)
		out_stall <= !calm && ($urandom_range(99) < 28);

	// Check each result word against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result word", out_channel, -1);
			end else begin
				want = pending_results.pop_front();
				if (out_channel !== want.ch)
					report_mismatch("out_channel", out_channel, want.ch);
				if (filtered_sample !== want.smp)
					report_mismatch("filtered_sample", filtered_sample, $signed(want.smp));
				if (out_block_end !== want.blk)
					report_mismatch("out_block_end", out_block_end, want.blk);
				if (bad_channel !== want.bad)
					report_mismatch("bad_channel", bad_channel, want.bad);
			end
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG) begin
			$display("FAIL biquad_cascade_lowpass");
			$finish;
		end
	end

	initial begin
		int i;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		channel      = '0;
		sample       = '0;
		block_end    = 1'b0;
		calm         = 1'b0;
		errors       = 0;
		for (i = 0; i < NUM_COEFF_REGS; i++)
			stage_coeff[i] = '0;
		active_count = CHANNELS_RESET;
		for (i = 0; i < MAX_CH * NSEC; i++) begin
			delay_first[i]  = '0;
			delay_second[i] = '0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_passthrough();
		test_saturation();
		test_channel_count();
		test_sender_pause();
		test_random_filtering();

		wait_idle();
		repeat (2 * LATENCY) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never delivered", pending_results.size(), 0);
		if (errors == 0)
			$display("PASS biquad_cascade_lowpass");
		else
			$display("FAIL biquad_cascade_lowpass");
		$finish;
	end

endmodule
